// ===== hdl/tmp_pkg.sv =====
// Shared types, constants and helpers for the trapezoidal motion profile core.
package tmp_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned WIDE_W       = 64;
   localparam int unsigned DIV_DEN_W    = 33;
   localparam int unsigned DIST_W       = 31;
   localparam int unsigned STEP_W       = 24;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned FRAC_BITS_DEF = 16;

   localparam logic [DATA_W-1:0] MAX_VELOCITY_RST = 32'd16384;
   localparam logic [DATA_W-1:0] ACCELERATION_RST = 32'd16384;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VELOCITY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCELERATION = 1'd1;

   localparam logic [1:0] PHASE_ACCEL   = 2'd0;
   localparam logic [1:0] PHASE_CRUISE  = 2'd1;
   localparam logic [1:0] PHASE_DECEL   = 2'd2;
   localparam logic [1:0] PHASE_STOPPED = 2'd3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [DIST_W-1:0] distance;
      logic [STEP_W-1:0] time_step;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic [1:0]               phase;
      logic                     fault;
   } rsp_word_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_AX_ZERO_A,
      OP_DIV_RAMP_GO,
      OP_RAMP_SET,
      OP_MUL_VV,
      OP_DIV_AX_GO,
      OP_AX_SET,
      OP_START_APPLY,
      OP_ADVANCE,
      OP_FAULT_FINISH,
      OP_FINISH,
      OP_ACC_PREP,
      OP_HALF1,
      OP_HALF2,
      OP_ACC_END,
      OP_CRUISE_MUL,
      OP_CRUISE_END,
      OP_DEC_DIV_GO,
      OP_DEC_Q_OVF,
      OP_SQRT_GO,
      OP_TR_SET,
      OP_DEC_PREP,
      OP_DEC_END,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic is_tick;
      logic running;
      logic accel_zero;
      logic cur_lt_aep;
      logic cur_lt_dsp;
      logic div_done;
      logic sqrt_done;
      logic q_ovf;
      logic dec_stop;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RAMP_WAIT,
      ST_VV,
      ST_AX_DIV,
      ST_AX_WAIT,
      ST_APPLY,
      ST_BRANCH,
      ST_ACC_M1,
      ST_ACC_M2,
      ST_ACC_END,
      ST_CRU_END,
      ST_DEC_WAIT,
      ST_SQRT_WAIT,
      ST_DEC_CHK,
      ST_DEC_M1,
      ST_DEC_M2,
      ST_DEC_END,
      ST_OUT
   } ctrl_state_type;

   function automatic logic [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] v);
      return (v[WIDE_W-1:DATA_W] != '0) ? '1 : v[DATA_W-1:0];
   endfunction

endpackage

// ===== hdl/tmp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tmp_div import tmp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDE_W-1:0]    dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [WIDE_W-1:0]    quotient
);

   localparam int unsigned CNT_W = $clog2(WIDE_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [WIDE_W-1:0]    quo_ff, quo_in;

   always_comb begin
      logic [DIV_DEN_W:0] trial;
      trial   = {rem_ff, quo_ff[WIDE_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/tmp_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module tmp_sqrt import tmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] value,
   output logic              done,
   output logic [DATA_W-1:0] root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WIDE_W-1:0] v_ff, v_in;
   logic [WIDE_W-1:0] root_ff, root_in;
   logic [WIDE_W-1:0] bit_ff, bit_in;

   always_comb begin
      logic [WIDE_W-1:0] sum;
      sum     = root_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = value;
         root_in = '0;
         bit_in  = WIDE_W'(1) << (WIDE_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= sum) begin
            v_in    = v_ff - sum;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == WIDE_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[DATA_W-1:0];

endmodule

// ===== hdl/tmp_datapath.sv =====
// Profile datapath: move state, multiplier, divider and square root units.
module tmp_datapath import tmp_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  req_word_type      req_data,
   input  logic [DATA_W-1:0] max_velocity,
   input  logic [DATA_W-1:0] acceleration,
   input  dp_op_type         op,
   output dp_status_type     status,
   output rsp_word_type      rsp_data
);

   // item
   logic              cmd_ff, cmd_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [STEP_W-1:0] dt_ff, dt_in;
   // move state
   logic              running_ff, running_in;
   logic [DATA_W-1:0] et_ff, et_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] end_ff, end_in;
   logic [DATA_W-1:0] aep_ff, aep_in;
   logic [DATA_W-1:0] dsp_ff, dsp_in;
   logic [DATA_W-1:0] ramp_ff, ramp_in;
   // scratch
   logic [WIDE_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [DATA_W-1:0] tvar_ff, tvar_in;
   logic [DATA_W-1:0] hpos_ff, hpos_in;
   logic [DATA_W-1:0] tr_ff, tr_in;
   logic              ge_ff, ge_in;
   logic [1:0]        phase_ff, phase_in;
   logic              fault_ff, fault_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic                 div_start;
   logic [WIDE_W-1:0]    div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [WIDE_W-1:0]    div_q;
   logic                 sqrt_start;
   logic                 sqrt_done;
   logic [DATA_W-1:0]    sqrt_root;

   logic [DATA_W-1:0] half;
   logic [DATA_W-1:0] rem;
   logic [DATA_W-1:0] dt_ext;

   assign half   = DATA_W'(dist_ff[DIST_W-1:1]);
   assign rem    = (end_ff > cur_ff) ? end_ff - cur_ff : '0;
   assign dt_ext = DATA_W'(dt_ff);

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = {1'b0, acceleration};
      unique case (op)
         OP_DIV_RAMP_GO: begin
            div_start = 1'b1;
            div_num   = WIDE_W'(max_velocity) << FRAC_BITS;
         end
         OP_DIV_AX_GO: begin
            div_start = 1'b1;
            div_num   = prod_ff;
            div_den   = {acceleration, 1'b0};
         end
         OP_DEC_DIV_GO: begin
            div_start = 1'b1;
            div_num   = WIDE_W'(rem) << (FRAC_BITS + 1);
         end
         default: ;
      endcase
   end

   assign sqrt_start = (op == OP_SQRT_GO);

   tmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   tmp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (div_q << FRAC_BITS),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_comb begin
      logic [WIDE_W-1:0] mul;
      logic [DATA_W-1:0] qs;
      logic [DATA_W-1:0] diff;
      logic [DATA_W-1:0] dsat;
      logic [DATA_W:0]   sum;
      logic [DATA_W-1:0] pos;
      logic              run;

      mul  = '0;
      qs   = sat32(div_q);
      diff = '0;
      dsat = sat32(prod_ff >> FRAC_BITS);
      sum  = {1'b0, aep_ff} + {1'b0, dsat};
      pos  = '0;
      run  = 1'b0;

      cmd_in     = cmd_ff;
      dist_in    = dist_ff;
      dt_in      = dt_ff;
      running_in = running_ff;
      et_in      = et_ff;
      cur_in     = cur_ff;
      end_in     = end_ff;
      aep_in     = aep_ff;
      dsp_in     = dsp_ff;
      ramp_in    = ramp_ff;
      prod_in    = prod_ff;
      p_in       = p_ff;
      tvar_in    = tvar_ff;
      hpos_in    = hpos_ff;
      tr_in      = tr_ff;
      ge_in      = ge_ff;
      phase_in   = phase_ff;
      fault_in   = fault_ff;
      rsp_in     = rsp_ff;

      unique case (op)
         OP_LOAD: begin
            cmd_in   = req_data.cmd;
            dist_in  = req_data.distance;
            dt_in    = req_data.time_step;
            phase_in = PHASE_STOPPED;
            fault_in = 1'b0;
         end
         OP_AX_ZERO_A: begin
            ramp_in = '1;
            aep_in  = half;
         end
         OP_RAMP_SET: ramp_in = qs;
         OP_MUL_VV: begin
            prod_in = WIDE_W'(max_velocity) * WIDE_W'(max_velocity);
         end
         OP_AX_SET: aep_in = (qs > half) ? half : qs;
         OP_START_APPLY: begin
            run    = (dist_ff != '0);
            end_in = DATA_W'(dist_ff);
            dsp_in = DATA_W'(dist_ff) - aep_ff;
            et_in  = '0;
            if (run && acceleration == '0) begin
               cur_in     = DATA_W'(dist_ff);
               running_in = 1'b0;
               fault_in   = 1'b1;
               phase_in   = PHASE_STOPPED;
            end else begin
               cur_in     = '0;
               running_in = run;
               if (run)
                  phase_in = (aep_ff != '0) ? PHASE_ACCEL : PHASE_CRUISE;
               else
                  phase_in = PHASE_STOPPED;
            end
         end
         OP_ADVANCE: et_in = sat32(WIDE_W'(et_ff) + WIDE_W'(dt_ff));
         OP_FAULT_FINISH: begin
            cur_in     = end_ff;
            running_in = 1'b0;
            fault_in   = 1'b1;
            phase_in   = PHASE_STOPPED;
         end
         OP_FINISH: begin
            cur_in     = end_ff;
            running_in = 1'b0;
            phase_in   = PHASE_STOPPED;
         end
         OP_ACC_PREP: begin
            phase_in = PHASE_ACCEL;
            tvar_in  = et_ff;
         end
         OP_HALF1: begin
            mul  = WIDE_W'(acceleration) * WIDE_W'(tvar_ff);
            p_in = sat32(mul >> FRAC_BITS);
         end
         OP_HALF2: begin
            mul     = WIDE_W'(p_ff) * WIDE_W'(tvar_ff);
            hpos_in = sat32(mul >> (FRAC_BITS + 1));
         end
         OP_ACC_END: begin
            if (hpos_ff >= end_ff) begin
               cur_in     = end_ff;
               running_in = 1'b0;
               phase_in   = PHASE_STOPPED;
            end else begin
               cur_in = hpos_ff;
            end
         end
         OP_CRUISE_MUL: begin
            phase_in = PHASE_CRUISE;
            ge_in    = (et_ff >= ramp_ff);
            diff     = (et_ff >= ramp_ff) ? et_ff - ramp_ff : ramp_ff - et_ff;
            prod_in  = WIDE_W'(max_velocity) * WIDE_W'(diff);
         end
         OP_CRUISE_END: begin
            if (ge_ff)
               pos = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            else
               pos = (dsat >= aep_ff) ? '0 : aep_ff - dsat;
            if (pos >= end_ff) begin
               cur_in     = end_ff;
               running_in = 1'b0;
               phase_in   = PHASE_STOPPED;
            end else begin
               cur_in = pos;
            end
         end
         OP_DEC_DIV_GO: phase_in = PHASE_DECEL;
         OP_DEC_Q_OVF:  tr_in = '1;
         OP_TR_SET:     tr_in = sqrt_root;
         OP_DEC_PREP:   tvar_in = tr_ff - dt_ext;
         OP_DEC_END:    cur_in = (hpos_ff >= end_ff) ? '0 : end_ff - hpos_ff;
         OP_OUT: begin
            rsp_in.position = signed'(cur_ff);
            rsp_in.phase    = phase_ff;
            rsp_in.fault    = fault_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         et_ff      <= '0;
         cur_ff     <= '0;
         end_ff     <= '0;
         aep_ff     <= '0;
         dsp_ff     <= '0;
         ramp_ff    <= '0;
      end else begin
         running_ff <= running_in;
         et_ff      <= et_in;
         cur_ff     <= cur_in;
         end_ff     <= end_in;
         aep_ff     <= aep_in;
         dsp_ff     <= dsp_in;
         ramp_ff    <= ramp_in;
      end
      cmd_ff   <= cmd_in;
      dist_ff  <= dist_in;
      dt_ff    <= dt_in;
      prod_ff  <= prod_in;
      p_ff     <= p_in;
      tvar_ff  <= tvar_in;
      hpos_ff  <= hpos_in;
      tr_ff    <= tr_in;
      ge_ff    <= ge_in;
      phase_ff <= phase_in;
      fault_ff <= fault_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      status.is_tick    = (cmd_ff == CMD_TICK);
      status.running    = running_ff;
      status.accel_zero = (acceleration == '0);
      status.cur_lt_aep = (cur_ff < aep_ff);
      status.cur_lt_dsp = (cur_ff < dsp_ff);
      status.div_done   = div_done;
      status.sqrt_done  = sqrt_done;
      status.q_ovf      = ((div_q >> (WIDE_W - FRAC_BITS)) != '0);
      status.dec_stop   = (rem == '0) || (dt_ext >= tr_ff);
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/tmp_ctrl.sv =====
// Sequencing state machine for the profile datapath.
module tmp_ctrl import tmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_op_type     op
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      logic out_free;
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      op           = OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.is_tick) begin
               if (status.accel_zero) begin
                  op       = OP_AX_ZERO_A;
                  state_in = ST_APPLY;
               end else begin
                  op       = OP_DIV_RAMP_GO;
                  state_in = ST_RAMP_WAIT;
               end
            end else if (!status.running) begin
               state_in = ST_OUT;
            end else begin
               op       = OP_ADVANCE;
               state_in = ST_BRANCH;
            end
         end
         ST_RAMP_WAIT: begin
            if (status.div_done) begin
               op       = OP_RAMP_SET;
               state_in = ST_VV;
            end
         end
         ST_VV: begin
            op       = OP_MUL_VV;
            state_in = ST_AX_DIV;
         end
         ST_AX_DIV: begin
            op       = OP_DIV_AX_GO;
            state_in = ST_AX_WAIT;
         end
         ST_AX_WAIT: begin
            if (status.div_done) begin
               op       = OP_AX_SET;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            op       = OP_START_APPLY;
            state_in = ST_OUT;
         end
         ST_BRANCH: begin
            priority if (status.accel_zero) begin
               op       = OP_FAULT_FINISH;
               state_in = ST_OUT;
            end else if (status.cur_lt_aep) begin
               op       = OP_ACC_PREP;
               state_in = ST_ACC_M1;
            end else if (status.cur_lt_dsp) begin
               op       = OP_CRUISE_MUL;
               state_in = ST_CRU_END;
            end else begin
               op       = OP_DEC_DIV_GO;
               state_in = ST_DEC_WAIT;
            end
         end
         ST_ACC_M1: begin
            op       = OP_HALF1;
            state_in = ST_ACC_M2;
         end
         ST_ACC_M2: begin
            op       = OP_HALF2;
            state_in = ST_ACC_END;
         end
         ST_ACC_END: begin
            op       = OP_ACC_END;
            state_in = ST_OUT;
         end
         ST_CRU_END: begin
            op       = OP_CRUISE_END;
            state_in = ST_OUT;
         end
         ST_DEC_WAIT: begin
            if (status.div_done) begin
               if (status.q_ovf) begin
                  op       = OP_DEC_Q_OVF;
                  state_in = ST_DEC_CHK;
               end else begin
                  op       = OP_SQRT_GO;
                  state_in = ST_SQRT_WAIT;
               end
            end
         end
         ST_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               op       = OP_TR_SET;
               state_in = ST_DEC_CHK;
            end
         end
         ST_DEC_CHK: begin
            if (status.dec_stop) begin
               op       = OP_FINISH;
               state_in = ST_OUT;
            end else begin
               op       = OP_DEC_PREP;
               state_in = ST_DEC_M1;
            end
         end
         ST_DEC_M1: begin
            op       = OP_HALF1;
            state_in = ST_DEC_M2;
         end
         ST_DEC_M2: begin
            op       = OP_HALF2;
            state_in = ST_DEC_END;
         end
         ST_DEC_END: begin
            op       = OP_DEC_END;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               op           = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/trapezoidal_motion_profile_core.sv =====
// Top level of the trapezoidal motion profile core.
//
// Usage: csr_ writes set max_velocity (index 0) and acceleration (index 1);
// csr_ready is always high and a write lands the cycle it is accepted.
// Writes must be made only while no word is in flight; the core does not enforce this.
// Each req_ word is a start (cmd 0, distance) or a tick (cmd 1, time_step)
// and yields exactly one rsp_ word: position, phase and fault.
// A start with nonzero acceleration makes two passes of the divider, which
// works one quotient bit per cycle; a decelerate tick makes a divider pass
// and then, unless its quotient overflows, a square-root pass. One word is
// worked at a time; req_ready is high only in the idle state.
// The result sits in an output register; while the receiver stalls the
// core still accepts and works the next word, then holds until the output
// register frees.
// Reset (synchronous, active high) stops any move, zeroes position and
// profile state, and restores both registers to 16384.
module trapezoidal_motion_profile_core import tmp_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   logic [DATA_W-1:0] max_velocity_ff, max_velocity_in;
   logic [DATA_W-1:0] acceleration_ff, acceleration_in;
   dp_op_type         op;
   dp_status_type     status;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      max_velocity_in = max_velocity_ff;
      acceleration_in = acceleration_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_VELOCITY: max_velocity_in = csr_data;
            CSR_ACCELERATION: acceleration_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_velocity_ff <= MAX_VELOCITY_RST;
         acceleration_ff <= ACCELERATION_RST;
      end else begin
         max_velocity_ff <= max_velocity_in;
         acceleration_ff <= acceleration_in;
      end
   end

   tmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   tmp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .max_velocity (max_velocity_ff),
      .acceleration (acceleration_ff),
      .op           (op),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== sim/trapezoidal_motion_profile_core_tb.sv =====
// Self-checking testbench for the trapezoidal motion profile core.
`timescale 1ns / 1ps

module trapezoidal_motion_profile_core_tb;
   import tmp_pkg::*;

   localparam int unsigned HALF_PERIOD = 10;
   localparam int unsigned CYCLE_LIMIT = 6000000;
   localparam int unsigned DRAIN_WAIT  = 300;
   localparam int unsigned NUM_SETS    = 12;
   localparam logic [63:0] ALL32       = 64'hFFFF_FFFF;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_word_type  req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_word_type  rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_data;

   trapezoidal_motion_profile_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // words waiting to be sent, and profile points still owed by the core
   req_word_type pending_words[$];
   rsp_word_type owed_points[$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;

   // ---------------------------------------------------------------
   // Profile predictor: own copy of registers and move state
   // ---------------------------------------------------------------
   logic [63:0] vel_reg, acc_reg;
   logic        mv_running;
   logic [63:0] mv_elapsed, mv_pos, mv_end, mv_accel_end, mv_decel_start, mv_ramp;

   function automatic logic [63:0] clip32(input logic [63:0] v);
      return (v > ALL32) ? ALL32 : v;
   endfunction

   // 0.5*a*t^2, each product truncated and clipped to 32 bits
   function automatic logic [63:0] ramp_distance(input logic [63:0] a, input logic [63:0] t);
      logic [63:0] p;
      p = clip32((a * t) >> FRAC_BITS_DEF);
      return clip32((p * t) >> (FRAC_BITS_DEF + 1));
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root, bitv, rem;
      root = 0;
      rem  = v;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   task automatic profile_reset();
      vel_reg = 64'(MAX_VELOCITY_RST);
      acc_reg = 64'(ACCELERATION_RST);
      mv_running = 1'b0;
      mv_elapsed = 0; mv_pos = 0; mv_end = 0;
      mv_accel_end = 0; mv_decel_start = 0; mv_ramp = 0;
   endtask

   task automatic stop_at_end();
      mv_pos = mv_end;
      mv_running = 1'b0;
   endtask

   // Works out the point the core must return for one accepted word.
   task automatic profile_step(input req_word_type w);
      logic [1:0]  ph;
      logic        flt;
      logic [63:0] path_len, half, ax, dt, pos, d, rem, q, tr;
      rsp_word_type pt;
      ph  = PHASE_STOPPED;
      flt = 1'b0;
      if (w.cmd == CMD_START) begin
         path_len = 64'(w.distance);
         half = path_len >> 1;
         if (acc_reg == 0) begin
            mv_ramp = ALL32;
            ax = half;
         end else begin
            mv_ramp = clip32((vel_reg << FRAC_BITS_DEF) / acc_reg);
            ax = clip32((vel_reg * vel_reg) / (acc_reg << 1));
            if (ax > half) ax = half;
         end
         mv_end = path_len;
         mv_accel_end = ax;
         mv_decel_start = path_len - ax;
         mv_elapsed = 0;
         mv_pos = 0;
         mv_running = (path_len != 0);
         // zero acceleration: jump to the end and flag it
         if (mv_running && acc_reg == 0) begin
            stop_at_end();
            flt = 1'b1;
         end
         if (mv_running) ph = (mv_accel_end > 0) ? PHASE_ACCEL : PHASE_CRUISE;
      end else if (mv_running) begin
         dt = 64'(w.time_step);
         mv_elapsed = clip32(mv_elapsed + dt);
         if (acc_reg == 0) begin
            stop_at_end();
            flt = 1'b1;
         end else if (mv_pos < mv_accel_end) begin
            pos = ramp_distance(acc_reg, mv_elapsed);
            ph = PHASE_ACCEL;
            if (pos >= mv_end) stop_at_end();
            else mv_pos = pos;
         end else if (mv_pos < mv_decel_start) begin
            ph = PHASE_CRUISE;
            if (mv_elapsed >= mv_ramp) begin
               d = (vel_reg * (mv_elapsed - mv_ramp)) >> FRAC_BITS_DEF;
               pos = clip32(mv_accel_end + clip32(d));
            end else begin
               // still short of the ramp time: back off from x1, floor at zero
               d = clip32((vel_reg * (mv_ramp - mv_elapsed)) >> FRAC_BITS_DEF);
               pos = (d >= mv_accel_end) ? 64'd0 : mv_accel_end - d;
            end
            if (pos >= mv_end) stop_at_end();
            else mv_pos = pos;
         end else begin
            ph = PHASE_DECEL;
            rem = (mv_end > mv_pos) ? mv_end - mv_pos : 64'd0;
            q = (rem << (FRAC_BITS_DEF + 1)) / acc_reg;
            if (q > (64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS_DEF)) tr = ALL32;
            else tr = clip32(int_sqrt(q << FRAC_BITS_DEF));
            if (rem == 0 || dt >= tr) begin
               stop_at_end();
            end else begin
               d = ramp_distance(acc_reg, tr - dt);
               mv_pos = (d >= mv_end) ? 64'd0 : mv_end - d;
            end
         end
         if (!mv_running) ph = PHASE_STOPPED;
      end
      pt.position = mv_pos[31:0];
      pt.phase    = ph;
      pt.fault    = flt;
      owed_points.push_back(pt);
   endtask

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps
   // ---------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   logic        req_hold;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         req_hold = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            profile_step(req_data);
            void'(pending_words.pop_front());
         end
         if (!req_hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_words[0];
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  // some bursts run back to back
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor: receiver stalls in runs of its own
   // ---------------------------------------------------------------
   int unsigned stall_run = 0;
   int unsigned flow_run  = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: %s got %0d want %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_points.size() == 0) begin
               report("unexpected word, position", rsp_data.position, 0);
            end else begin
               if (rsp_data.position !== owed_points[0].position)
                  report("position", rsp_data.position, owed_points[0].position);
               if (rsp_data.phase !== owed_points[0].phase)
                  report("phase", rsp_data.phase, owed_points[0].phase);
               if (rsp_data.fault !== owed_points[0].fault)
                  report("fault", rsp_data.fault, owed_points[0].fault);
               void'(owed_points.pop_front());
            end
         end
         if (stall_run > 0) begin
            stall_run--;
            rsp_ready <= 1'b0;
         end else if (flow_run > 0) begin
            flow_run--;
            rsp_ready <= 1'b1;
         end else begin
            flow_run  = $urandom_range(0, 40);
            stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trapezoidal_motion_profile_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic req_word_type make_word(input logic cmd, input logic [30:0] path_len,
                                              input logic [23:0] dt);
      req_word_type w;
      w.cmd = cmd;
      w.distance = path_len;
      w.time_step = dt;
      return w;
   endfunction

   function automatic logic [31:0] rand_width(input int unsigned maxw);
      int unsigned wd;
      wd = $urandom_range(1, maxw);
      return $urandom & ((wd >= 32) ? 32'hFFFF_FFFF : ((32'd1 << wd) - 1));
   endfunction

   // one move: a start then a run of ticks, with an occasional further start, and random step sizes
   task automatic queue_move();
      int unsigned n;
      int unsigned dtw;
      n = $urandom_range(2, 30);
      dtw = $urandom_range(4, 24);
      pending_words.push_back(make_word(CMD_START, 31'(rand_width(31)),
                                        24'(rand_width(24))));
      repeat (n) begin
         if ($urandom_range(0, 15) == 0)
            pending_words.push_back(make_word(CMD_START, 31'(rand_width(31)),
                                              24'(rand_width(24))));
         else
            pending_words.push_back(make_word(CMD_TICK, 31'(rand_width(31)),
                                              24'(rand_width(dtw))));
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MAX_VELOCITY) vel_reg = 64'(val);
      else vel_reg = vel_reg;
      if (idx == CSR_ACCELERATION) acc_reg = 64'(val);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || owed_points.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   logic [31:0] set_vel[NUM_SETS];
   logic [31:0] set_acc[NUM_SETS];

   initial begin
      reset     <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      profile_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings
      pending_words.push_back(make_word(CMD_TICK, 31'h7FFF_FFFF, 24'hFF_FFFF)); // stopped tick
      pending_words.push_back(make_word(CMD_START, 31'd0, 24'hFF_FFFF));        // zero length
      pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'd0));
      pending_words.push_back(make_word(CMD_START, 31'h7FFF_FFFF, 24'd0));      // longest path
      pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'd0));
      pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'hFF_FFFF));
      pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'hFF_FFFF));
      pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'hFF_FFFF));
      // short path: accel distance clipped, cruise starts before ramp time
      pending_words.push_back(make_word(CMD_START, 31'd3, 24'd0));
      repeat (4) pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'h00_8000));
      pending_words.push_back(make_word(CMD_START, 31'd1, 24'd0));
      repeat (3) pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'h01_0000));
      pending_words.push_back(make_word(CMD_START, 31'h0004_0000, 24'd0));
      repeat (6) pending_words.push_back(make_word(CMD_TICK, 31'd0, 24'h04_0000));
      wait_idle();

      // register settings, extremes first, then random
      set_vel[0] = 32'hFFFF_FFFF; set_acc[0] = 32'hFFFF_FFFF;
      set_vel[1] = 32'd0;         set_acc[1] = 32'd16384;    // holds in cruise
      set_vel[2] = 32'd16384;     set_acc[2] = 32'd0;        // fault on start and tick
      set_vel[3] = 32'd1;         set_acc[3] = 32'hFFFF_FFFF;
      set_vel[4] = 32'hFFFF_FFFF; set_acc[4] = 32'd1;
      set_vel[5] = 32'h0001_0000; set_acc[5] = 32'h0004_0000;
      set_vel[6] = 32'h0100_0000; set_acc[6] = 32'h0000_0100;
      for (int i = 7; i < NUM_SETS; i++) begin
         set_vel[i] = rand_width(32);
         set_acc[i] = rand_width(32);
      end

      for (int s = 0; s < NUM_SETS; s++) begin
         csr_write(CSR_MAX_VELOCITY, set_vel[s]);
         csr_write(CSR_ACCELERATION, set_acc[s]);
         // leftover move from the previous setting gets a few ticks first
         repeat (2) pending_words.push_back(make_word(CMD_TICK, 31'(rand_width(31)),
                                                      24'(rand_width(24))));
         while (pending_words.size() < 80) queue_move();
         wait_idle();
      end

      if (error_count == 0) begin
         $display("trapezoidal_motion_profile_core: match");
      end else begin
         $display("trapezoidal_motion_profile_core: mismatch");
      end
      $finish;
   end

endmodule
